/* rtl/lpba_pkg.sv */
// Shared constants, codes and types of the link period budget allocator.
package lpba_pkg;

   // Field widths
   localparam int BUDGET_W  = 16;
   localparam int TIMEOUT_W = 16;
   localparam int SHOFF_W   = 17;
   localparam int OFFSET_W  = 17;
   localparam int PERIOD_W  = 4;
   localparam int LINKS_W   = 5;
   localparam int DIV_W     = 6;   // min_links + 1, at most 32
   localparam int UNIT_W    = 22;  // divisor times 2^16
   localparam int CSR_IDX_W = 2;

   localparam int MAX_LINKS_DEFAULT = 16;

   // Largest period exponent
   localparam logic [PERIOD_W-1:0] PERIOD_MAX = 4'd15;

   // Command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BUDGET    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LINKS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRATEGY_MODE = 2'd2;

   // Register reset values
   localparam logic [BUDGET_W-1:0] MAX_BUDGET_RESET = 16'd6554;
   localparam logic [LINKS_W-1:0]  MIN_LINKS_RESET  = 5'd4;
   localparam logic                STRATEGY_RESET   = 1'b0;

   // Strategy codes
   localparam logic MODE_STATIC  = 1'b0;
   localparam logic MODE_DYNAMIC = 1'b1;

   // One table entry
   typedef struct packed {
      logic [BUDGET_W-1:0]  budget;
      logic [TIMEOUT_W-1:0] timeout;
   } entry_type;

endpackage

/* rtl/lpba_table.sv */
// Link table: one synchronous memory of budget and timeout entries.
module lpba_table #(
   parameter int DEPTH = lpba_pkg::MAX_LINKS_DEFAULT,
   parameter int AW    = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  lpba_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output lpba_pkg::entry_type rd_data
);

   lpba_pkg::entry_type mem [DEPTH];
   lpba_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lpba_period.sv */
// Period exponent search: least n with 10*avail*2^n >= unit, saturated.
module lpba_period #(
   parameter int A10W = 32
) (
   input  logic [A10W-1:0]                 a10,
   input  logic [lpba_pkg::UNIT_W-1:0]     unit,
   output logic [lpba_pkg::PERIOD_W-1:0]   period
);

   localparam int SW    = A10W + 14;
   localparam int STEPS = 15;

   logic [STEPS-1:0] ge;
   logic [SW-1:0]    unit_ext;

   assign unit_ext = SW'(unit);

   always_comb begin
      for (int n = 0; n < STEPS; n++) begin
         ge[n] = ((SW'(a10) << n) >= unit_ext) && (a10 != '0);
      end
   end

   // take the lowest exponent that meets the bound
   always_comb begin
      period = lpba_pkg::PERIOD_MAX;
      for (int n = STEPS - 1; n >= 0; n--) begin
         if (ge[n]) begin
            period = lpba_pkg::PERIOD_W'(n);
         end
      end
   end

endmodule

/* rtl/link_period_budget_allocator_unit.sv */
// Top level of the link period budget allocator: control sequencer and registers.
// Load: written into the table from the idle state; static evaluate: init, then emit to the result register.
// Dynamic evaluate: init, a table walk over the N links, then check; each reclaim round is a
//   search walk and a pick, back to check; at most N+1 reclaim rounds.
// No input is taken from evaluate acceptance until the result is registered; a held
//   result stalls the emit. Reset (synchronous): control registers reset, table emptied.
module link_period_budget_allocator_unit #(
   parameter int MAX_LINKS = lpba_pkg::MAX_LINKS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic [lpba_pkg::BUDGET_W-1:0]        req_pp_budget,
   input  logic [lpba_pkg::TIMEOUT_W-1:0]       req_pp_timeout,
   input  logic [lpba_pkg::BUDGET_W-1:0]        req_sh_budget,
   input  logic signed [lpba_pkg::SHOFF_W-1:0]  req_sh_offset,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [lpba_pkg::OFFSET_W-1:0]        rsp_min_offset,
   output logic [lpba_pkg::PERIOD_W-1:0]        rsp_min_period,
   output logic                                 rsp_status,
   // configuration
   input  logic                                 csr_write_enable,
   input  logic [lpba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lpba_pkg::BUDGET_W-1:0]        csr_write_data
);

   // Address and count widths follow the table depth
   localparam int AW   = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
   localparam int CW   = $clog2(MAX_LINKS + 1);
   // Scaled budgets: each Q0.16 budget times the divisor; room for every link plus sign
   localparam int AVW  = 21 + $clog2(MAX_LINKS + 1) + 2;
   localparam int A10W = AVW + 4;
   localparam int PW   = lpba_pkg::BUDGET_W + lpba_pkg::DIV_W;
   localparam int HW   = AVW + 7;

   localparam logic [CW-1:0]         COUNT_MAX = CW'(MAX_LINKS);
   localparam logic signed [HW-1:0]  HUNDRED   = HW'(100);
   localparam logic [A10W-1:0]       TEN       = A10W'(10);

   // Sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_INIT  = 3'd1;
   localparam logic [2:0] S_PASS  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_PICK  = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [lpba_pkg::BUDGET_W-1:0] max_budget_ff;
   logic [lpba_pkg::LINKS_W-1:0]  min_links_ff;
   logic                          mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_budget_ff <= lpba_pkg::MAX_BUDGET_RESET;
         min_links_ff  <= lpba_pkg::MIN_LINKS_RESET;
         mode_ff       <= lpba_pkg::STRATEGY_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == lpba_pkg::CSR_MAX_BUDGET) begin
            max_budget_ff <= csr_write_data;
         end
         if (csr_index == lpba_pkg::CSR_MIN_LINKS) begin
            min_links_ff <= csr_write_data[lpba_pkg::LINKS_W-1:0];
         end
         if (csr_index == lpba_pkg::CSR_STRATEGY_MODE) begin
            mode_ff <= csr_write_data[0];
         end
      end
   end

   // Effective link minimum (zero acts as one), divisor and unit
   logic [lpba_pkg::LINKS_W-1:0] links;
   logic [lpba_pkg::DIV_W-1:0]   div;
   logic [lpba_pkg::UNIT_W-1:0]  unit;

   assign links = (min_links_ff == '0) ? lpba_pkg::LINKS_W'(1) : min_links_ff;
   assign div   = lpba_pkg::DIV_W'(links) + lpba_pkg::DIV_W'(1);
   assign unit  = {div, 16'h0000};

   // ---------------------------------------------------------------
   // Sequencer registers
   // ---------------------------------------------------------------
   logic [2:0]                      state_ff, state_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [CW-1:0]                   idx_ff, idx_in;
   logic                            pend_ff, pend_in;
   logic [AW-1:0]                   pend_idx_ff, pend_idx_in;
   logic                            search_ff, search_in;
   logic [MAX_LINKS-1:0]            taken_ff, taken_in;
   logic                            sh_taken_ff, sh_taken_in;
   logic                            best_v_ff, best_v_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [lpba_pkg::BUDGET_W-1:0]   sh_budget_ff, sh_budget_in;
   logic [lpba_pkg::TIMEOUT_W-1:0]  sh_offset_ff, sh_offset_in;
   logic                            sh_present_ff, sh_present_in;
   logic signed [AVW-1:0]           avail_ff, avail_in;
   logic [A10W-1:0]                 a10_ff, a10_in;
   logic [lpba_pkg::OFFSET_W-1:0]   offset_ff, offset_in;
   logic                            fail_ff, fail_in;
   logic [lpba_pkg::TIMEOUT_W-1:0]  best_t_ff, best_t_in;
   logic [lpba_pkg::BUDGET_W-1:0]   best_b_ff, best_b_in;
   logic [AW-1:0]                   best_idx_ff, best_idx_in;
   logic [lpba_pkg::OFFSET_W-1:0]   rsp_offset_ff, rsp_offset_in;
   logic [lpba_pkg::PERIOD_W-1:0]   rsp_period_ff, rsp_period_in;
   logic                            rsp_status_ff, rsp_status_in;

   // ---------------------------------------------------------------
   // Table memory
   // ---------------------------------------------------------------
   logic                tbl_wr_en;
   lpba_pkg::entry_type tbl_wr_data;
   logic                tbl_rd_en;
   lpba_pkg::entry_type tbl_rd_data;

   assign tbl_wr_data.budget  = req_pp_budget;
   assign tbl_wr_data.timeout = req_pp_timeout;

   lpba_table #(
      .DEPTH (MAX_LINKS),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (tbl_rd_data)
   );

   // ---------------------------------------------------------------
   // Period search on the registered 10 * avail
   // ---------------------------------------------------------------
   logic [lpba_pkg::PERIOD_W-1:0] period;

   lpba_period #(
      .A10W (A10W)
   ) u_period (
      .a10    (a10_ff),
      .unit   (unit),
      .period (period)
   );

   // ---------------------------------------------------------------
   // Arithmetic shared by the states
   // ---------------------------------------------------------------
   // One budget-times-divisor multiplier: table read in the pass, reclaim in pick,
   // shared-channel share at init
   logic [lpba_pkg::BUDGET_W-1:0] mul_op;
   logic [PW-1:0]                 mul_prod;
   logic signed [AVW-1:0]         mul_s;
   logic [PW-1:0]                 maxs;
   logic                          share_fair;
   logic signed [AVW-1:0]         avail_init;
   logic signed [HW-1:0]          hundred_avail;
   logic                          enough;
   logic                          sh_pick;

   always_comb begin
      mul_op = sh_budget_ff;
      if (state_ff == S_PASS) begin
         mul_op = tbl_rd_data.budget;
      end else if (state_ff == S_PICK && !sh_pick) begin
         mul_op = best_b_ff;
      end
   end

   assign mul_prod = PW'(mul_op) * PW'(div);
   assign mul_s    = AVW'(mul_prod);
   assign maxs     = PW'(max_budget_ff) * PW'(div);

   // fair share applies once enough links are loaded and the shared channel uses less
   assign share_fair = (8'(count_ff) >= (8'(links) - 8'd1))
                       && (mul_prod < PW'(max_budget_ff));
   assign avail_init = AVW'(maxs) - (share_fair ? AVW'(max_budget_ff) : mul_s);

   // avail >= 0.01 of the unit, compared as signed so that a deficit never passes
   assign hundred_avail = HW'(avail_ff) * HUNDRED;
   assign enough        = hundred_avail >= $signed(HW'(unit));

   // shared channel wins only on a strictly earlier slot
   assign sh_pick = !sh_taken_ff && (!best_v_ff || (sh_offset_ff < best_t_ff));

   // ---------------------------------------------------------------
   // Next-state logic
   // ---------------------------------------------------------------
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      search_in     = search_ff;
      taken_in      = taken_ff;
      sh_taken_in   = sh_taken_ff;
      best_v_in     = best_v_ff;
      sh_budget_in  = sh_budget_ff;
      sh_offset_in  = sh_offset_ff;
      sh_present_in = sh_present_ff;
      avail_in      = avail_ff;
      a10_in        = a10_ff;
      offset_in     = offset_ff;
      fail_in       = fail_ff;
      best_t_in     = best_t_ff;
      best_b_in     = best_b_ff;
      best_idx_in   = best_idx_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_period_in = rsp_period_ff;
      rsp_status_in = rsp_status_ff;
      tbl_wr_en     = 1'b0;
      tbl_rd_en     = 1'b0;

      // drop the result once its transfer completes
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_command == lpba_pkg::CMD_LOAD) begin
                  // ignore loads into a full table
                  if (count_ff < COUNT_MAX) begin
                     tbl_wr_en = 1'b1;
                     count_in  = count_ff + CW'(1);
                  end
               end else begin
                  sh_budget_in  = req_sh_budget;
                  sh_offset_in  = req_sh_offset[lpba_pkg::TIMEOUT_W-1:0];
                  sh_present_in = !req_sh_offset[lpba_pkg::SHOFF_W-1];
                  state_in      = S_INIT;
               end
            end
         end

         S_INIT: begin
            offset_in = '0;
            fail_in   = 1'b0;
            if (mode_ff == lpba_pkg::MODE_STATIC) begin
               a10_in   = A10W'(max_budget_ff) * TEN;
               state_in = S_EMIT;
            end else begin
               avail_in    = avail_init;
               idx_in      = '0;
               pend_in     = 1'b0;
               search_in   = 1'b0;
               taken_in    = '0;
               sh_taken_in = !sh_present_ff;
               state_in    = S_PASS;
            end
         end

         S_PASS: begin
            // issue the next read, process the one returned from the last cycle
            if (idx_ff < count_ff) begin
               tbl_rd_en   = 1'b1;
               idx_in      = idx_ff + CW'(1);
               pend_in     = 1'b1;
               pend_idx_in = idx_ff[AW-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (!search_ff) begin
                  avail_in = avail_ff - mul_s;
               end else if (!taken_ff[pend_idx_ff]
                            && (!best_v_ff || (tbl_rd_data.timeout < best_t_ff))) begin
                  best_v_in   = 1'b1;
                  best_t_in   = tbl_rd_data.timeout;
                  best_b_in   = tbl_rd_data.budget;
                  best_idx_in = pend_idx_ff;
               end
            end
            if ((idx_ff == count_ff) && !pend_ff) begin
               state_in = search_ff ? S_PICK : S_CHECK;
            end
         end

         S_CHECK: begin
            if (enough) begin
               a10_in   = A10W'(avail_ff[AVW-2:0]) * TEN;
               state_in = S_EMIT;
            end else begin
               // start another search for the earliest timeout
               best_v_in = 1'b0;
               search_in = 1'b1;
               idx_in    = '0;
               pend_in   = 1'b0;
               state_in  = S_PASS;
            end
         end

         S_PICK: begin
            if (sh_pick) begin
               sh_taken_in = 1'b1;
               avail_in    = avail_ff + mul_s;
               offset_in   = lpba_pkg::OFFSET_W'(sh_offset_ff) + lpba_pkg::OFFSET_W'(1);
               state_in    = S_CHECK;
            end else if (best_v_ff) begin
               taken_in[best_idx_ff] = 1'b1;
               avail_in              = avail_ff + mul_s;
               offset_in = lpba_pkg::OFFSET_W'(best_t_ff) + lpba_pkg::OFFSET_W'(1);
               state_in  = S_CHECK;
            end else begin
               // nothing left to reclaim
               fail_in  = 1'b1;
               state_in = S_EMIT;
            end
         end

         S_EMIT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_offset_in = fail_ff ? '0 : offset_ff;
               rsp_period_in = fail_ff ? '0 : period;
               rsp_status_in = fail_ff;
               count_in      = '0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         search_ff    <= 1'b0;
         taken_ff     <= '0;
         sh_taken_ff  <= 1'b0;
         best_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         search_ff    <= search_in;
         taken_ff     <= taken_in;
         sh_taken_ff  <= sh_taken_in;
         best_v_ff    <= best_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff   <= pend_idx_in;
      sh_budget_ff  <= sh_budget_in;
      sh_offset_ff  <= sh_offset_in;
      sh_present_ff <= sh_present_in;
      avail_ff      <= avail_in;
      a10_ff        <= a10_in;
      offset_ff     <= offset_in;
      fail_ff       <= fail_in;
      best_t_ff     <= best_t_in;
      best_b_ff     <= best_b_in;
      best_idx_ff   <= best_idx_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_period_ff <= rsp_period_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_min_offset = rsp_offset_ff;
   assign rsp_min_period = rsp_period_ff;
   assign rsp_status     = rsp_status_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // the table never holds more entries than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("entry count beyond table depth");

   // a returned read always belongs to a loaded entry
   a_read_loaded: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (CW'(pend_idx_ff) < count_ff))
      else $error("read of an entry that was never loaded");

   // the table is empty again after each evaluation
   a_empty_after_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) && (state_in == S_IDLE) |=> (count_ff == '0))
      else $error("table not emptied after evaluation");

   // a no-budget answer carries zero offset and zero period
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> (rsp_offset_ff == '0) && (rsp_period_ff == '0))
      else $error("no-budget result with non-zero fields");

endmodule
